@@ rtl/slc_pkg.sv @@
// shared types and codes of the simd lane compare unit
package slc_pkg;

   // compare operations
   localparam logic [1:0] KIND_EQ  = 2'd0;
   localparam logic [1:0] KIND_SGT = 2'd1;
   localparam logic [1:0] KIND_UGT = 2'd2;

   // lane widths
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   // width of one lane slice and number of slices across the vector
   localparam int SLICE_W     = 32;
   localparam int SLICE_COUNT = 4;

   // per-request control shared by all lane slices
   typedef struct packed {
      logic [1:0]        kind;
      logic [1:0]        lane_size;
      logic              use_immediate;
      logic signed [9:0] immediate;
   } slc_ctrl_type;

endpackage

@@ rtl/simd_lane_compare_unit.sv @@
// top level of the simd lane compare unit
// Compares two 128-bit vectors, or a vector and a 10-bit immediate, in byte
// lanes (low immediate byte), halfword or word lanes (immediate sign-extended).
// A request is taken on every cycle that start is high; busy never rises, so
// one request per cycle is sustained. The result appears on the rsp_ ports
// with rsp_strobe for exactly one cycle, the cycle after the request was
// accepted, from the single result register behind the four 32-bit lane slices.
// The receiver must take it in that cycle, as it cannot hold results off.
module simd_lane_compare_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_kind,
   input  logic [1:0]        req_lane_size,
   input  logic              req_use_immediate,
   input  logic [63:0]       req_first_upper,
   input  logic [63:0]       req_first_lower,
   input  logic [63:0]       req_second_upper,
   input  logic [63:0]       req_second_lower,
   input  logic signed [9:0] req_immediate,
   output logic              rsp_strobe,
   output logic [63:0]       rsp_mask_upper,
   output logic [63:0]       rsp_mask_lower
);
   import slc_pkg::*;

   slc_ctrl_type                       ctrl;
   logic [SLICE_COUNT*SLICE_W-1:0]     vec_a;
   logic [SLICE_COUNT*SLICE_W-1:0]     vec_b;
   logic [SLICE_COUNT*SLICE_W-1:0]     slice_mask;
   logic                               fire;

   // the unit never stalls a request
   assign busy = 1'b0;
   assign fire = start & ~busy;

   assign ctrl.kind          = req_kind;
   assign ctrl.lane_size     = req_lane_size;
   assign ctrl.use_immediate = req_use_immediate;
   assign ctrl.immediate     = req_immediate;

   assign vec_a = {req_first_upper, req_first_lower};
   assign vec_b = {req_second_upper, req_second_lower};

   // four lane slices side by side
   for (genvar s = 0; s < SLICE_COUNT; s++) begin : g_slice
      slc_lane u_lane (
         .ctrl  (ctrl),
         .src_a (vec_a[s*SLICE_W +: SLICE_W]),
         .src_b (vec_b[s*SLICE_W +: SLICE_W]),
         .mask  (slice_mask[s*SLICE_W +: SLICE_W])
      );
   end

   // merge and register
   slc_merge u_merge (
      .clock          (clock),
      .reset          (reset),
      .fire           (fire),
      .ctrl           (ctrl),
      .slice_mask     (slice_mask),
      .rsp_strobe     (rsp_strobe),
      .rsp_mask_upper (rsp_mask_upper),
      .rsp_mask_lower (rsp_mask_lower)
   );

endmodule

@@ rtl/slc_lane.sv @@
// one 32-bit lane slice: byte compares chained into halfword and word results
module slc_lane (
   input  slc_pkg::slc_ctrl_type ctrl,
   input  logic [31:0]           src_a,
   input  logic [31:0]           src_b,
   output logic [31:0]           mask
);
   import slc_pkg::*;

   logic [31:0] imm_rep;
   logic [31:0] opnd_b;
   logic [3:0]  byte_top;
   logic [3:0]  byte_eq;
   logic [3:0]  byte_gt;
   logic        is_signed;

   // immediate broadcast across the slice at the lane width
   always_comb begin
      case (ctrl.lane_size)
         SIZE_BYTE: imm_rep = {4{ctrl.immediate[7:0]}};
         SIZE_HALF: imm_rep = {2{{{6{ctrl.immediate[9]}}, ctrl.immediate}}};
         default:   imm_rep = {{22{ctrl.immediate[9]}}, ctrl.immediate};
      endcase
   end

   assign opnd_b    = ctrl.use_immediate ? imm_rep : src_b;
   assign is_signed = (ctrl.kind == KIND_SGT);

   // which bytes carry the sign bit of their lane
   always_comb begin
      case (ctrl.lane_size)
         SIZE_BYTE: byte_top = 4'b1111;
         SIZE_HALF: byte_top = 4'b1010;
         default:   byte_top = 4'b1000;
      endcase
   end

   // per-byte equal and greater, sign bit flipped on lane tops for signed compares
   always_comb begin
      for (int j = 0; j < 4; j++) begin
         logic [7:0] xa;
         logic [7:0] xb;
         xa = src_a[j*8 +: 8]  ^ {is_signed & byte_top[j], 7'b0};
         xb = opnd_b[j*8 +: 8] ^ {is_signed & byte_top[j], 7'b0};
         byte_eq[j] = (xa == xb);
         byte_gt[j] = (xa > xb);
      end
   end

   // combine bytes into lane hits and expand to the mask
   always_comb begin
      logic [1:0] half_eq;
      logic [1:0] half_gt;
      logic       word_eq;
      logic       word_gt;
      half_eq[0] = byte_eq[1] & byte_eq[0];
      half_eq[1] = byte_eq[3] & byte_eq[2];
      half_gt[0] = byte_gt[1] | (byte_eq[1] & byte_gt[0]);
      half_gt[1] = byte_gt[3] | (byte_eq[3] & byte_gt[2]);
      word_eq    = half_eq[1] & half_eq[0];
      word_gt    = half_gt[1] | (half_eq[1] & half_gt[0]);
      case (ctrl.lane_size)
         SIZE_BYTE: begin
            for (int j = 0; j < 4; j++) begin
               mask[j*8 +: 8] = {8{(ctrl.kind == KIND_EQ) ? byte_eq[j] : byte_gt[j]}};
            end
         end
         SIZE_HALF: begin
            for (int j = 0; j < 2; j++) begin
               mask[j*16 +: 16] = {16{(ctrl.kind == KIND_EQ) ? half_eq[j] : half_gt[j]}};
            end
         end
         default: begin
            mask = {32{(ctrl.kind == KIND_EQ) ? word_eq : word_gt}};
         end
      endcase
   end

endmodule

@@ rtl/slc_merge.sv @@
// merging stage: gathers slice masks, drops undefined codes, registers the result
module slc_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  slc_pkg::slc_ctrl_type ctrl,
   input  logic [slc_pkg::SLICE_COUNT*slc_pkg::SLICE_W-1:0] slice_mask,
   output logic                  rsp_strobe,
   output logic [63:0]           rsp_mask_upper,
   output logic [63:0]           rsp_mask_lower
);
   import slc_pkg::*;

   logic         codes_ok;
   logic [127:0] mask_in;
   logic [127:0] mask_ff;
   logic         strobe_ff;

   // kind 3 or lane size 3 give an all-zero mask
   assign codes_ok = (ctrl.kind == KIND_EQ || ctrl.kind == KIND_SGT || ctrl.kind == KIND_UGT)
                  && (ctrl.lane_size == SIZE_BYTE || ctrl.lane_size == SIZE_HALF
                      || ctrl.lane_size == SIZE_WORD);
   assign mask_in  = codes_ok ? slice_mask : '0;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= fire;
      end
      if (fire) begin
         mask_ff <= mask_in;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_mask_upper = mask_ff[127:64];
   assign rsp_mask_lower = mask_ff[63:0];

endmodule
